@@ design/rc4v_pkg.sv @@
// Shared types and constants for the RC4-variant stream cipher core.
// No dependencies; imported by rc4v_seq and the top level.
package rc4v_pkg;

  localparam int KEY_BYTES = 256;   // largest key length kept in the key store
  localparam int TABLE_DEPTH = 256; // permutation table and key store depth
  localparam int ADDR_W = 8;

  localparam logic MODE_KEY = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       key_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       keyed;
  } out_t;

  // one write port and one read address per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ design/rc4v_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the permutation table and the key store.
module rc4v_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/rc4v_seq.sv @@
// Sequencer of the cipher: key loading, table init, key schedule and
// keystream generation, all through one port pair of each RAM.
// Depends on rc4v_pkg.
module rc4v_seq
  import rc4v_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_t      in_data_i,
  input  logic     slot_free_i,
  output logic     res_valid_o,
  output out_t     res_o,
  output ram_req_t perm_req_o,
  input  logic [7:0] perm_rdata_i,
  output ram_req_t key_req_o,
  input  logic [7:0] key_rdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_K_RD,
    ST_K_J,
    ST_K_WN,
    ST_K_WJ,
    ST_D_RJ,
    ST_D_WI,
    ST_D_WJ,
    ST_D_RK,
    ST_D_KS,
    ST_OUT
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  cnt_q, cnt_d;      // init / schedule position
  logic [7:0]  kpos_q, kpos_d;    // key store read position
  logic [8:0]  key_count_q, key_count_d;
  logic [7:0]  i_q, i_d;
  logic [7:0]  j_q, j_d;
  logic        keyed_q, keyed_d;
  logic [7:0]  si_q, si_d;
  logic [7:0]  sj_q, sj_d;
  logic [7:0]  byte_q, byte_d;
  out_t        res_q, res_d;
  logic        accept;
  logic [8:0]  kpos_inc;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);
  assign res_o      = res_q;
  assign kpos_inc   = {1'b0, kpos_q} + 9'd1;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    kpos_d      = kpos_q;
    key_count_d = key_count_q;
    i_d         = i_q;
    j_d         = j_q;
    keyed_d     = keyed_q;
    si_d        = si_q;
    sj_d        = sj_q;
    byte_d      = byte_q;
    res_d       = res_q;

    perm_req_o       = '0;
    perm_req_o.raddr = cnt_q;
    perm_req_o.waddr = cnt_q;
    key_req_o        = '0;
    key_req_o.raddr  = kpos_q;
    key_req_o.waddr  = key_count_q[ADDR_W-1:0];
    key_req_o.wdata  = in_data_i.data_byte;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          byte_d = in_data_i.data_byte;
          if (in_data_i.mode == MODE_KEY) begin
            if (key_count_q < 9'(KEY_BYTES)) begin
              key_req_o.we = 1'b1;
              key_count_d  = key_count_q + 9'd1;
            end
            if (in_data_i.key_last) begin
              cnt_d   = '0;
              state_d = ST_INIT;
            end
          end else if (keyed_q) begin
            i_d              = i_q + 8'd1;
            perm_req_o.raddr = i_q + 8'd1;
            state_d          = ST_D_RJ;
          end else begin
            res_d.out_byte = in_data_i.data_byte;
            res_d.keyed    = 1'b0;
            state_d        = ST_OUT;
          end
        end
      end
      ST_INIT: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.wdata = cnt_q;
        cnt_d            = cnt_q + 8'd1;
        if (cnt_q == 8'hFF) begin
          j_d     = '0;
          kpos_d  = '0;
          state_d = ST_K_RD;
        end
      end
      ST_K_RD: begin
        // read S[n] and key byte; raddr defaults already point there
        state_d = ST_K_J;
      end
      ST_K_J: begin
        si_d             = perm_rdata_i;
        j_d              = j_q + perm_rdata_i + key_rdata_i + 8'd1;
        perm_req_o.raddr = j_q + perm_rdata_i + key_rdata_i + 8'd1;
        state_d          = ST_K_WN;
      end
      ST_K_WN: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = cnt_q;
        perm_req_o.wdata = perm_rdata_i;
        state_d          = ST_K_WJ;
      end
      ST_K_WJ: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = j_q;
        perm_req_o.wdata = si_q;
        kpos_d = (kpos_inc >= key_count_q) ? 8'd0 : kpos_inc[7:0];
        cnt_d  = cnt_q + 8'd1;
        if (cnt_q == 8'hFF) begin
          i_d         = '0;
          j_d         = '0;
          keyed_d     = 1'b1;
          key_count_d = '0;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_K_RD;
        end
      end
      ST_D_RJ: begin
        si_d             = perm_rdata_i;
        j_d              = j_q + perm_rdata_i;
        perm_req_o.raddr = j_q + perm_rdata_i;
        state_d          = ST_D_WI;
      end
      ST_D_WI: begin
        sj_d             = perm_rdata_i;
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = i_q;
        perm_req_o.wdata = perm_rdata_i;
        state_d          = ST_D_WJ;
      end
      ST_D_WJ: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = j_q;
        perm_req_o.wdata = si_q;
        state_d          = ST_D_RK;
      end
      ST_D_RK: begin
        // issued after the swap writes so the read sees the new table
        perm_req_o.raddr = si_q + sj_q;
        state_d          = ST_D_KS;
      end
      ST_D_KS: begin
        res_d.out_byte = byte_q ^ perm_rdata_i;
        res_d.keyed    = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      kpos_q      <= '0;
      key_count_q <= '0;
      i_q         <= '0;
      j_q         <= '0;
      keyed_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      kpos_q      <= kpos_d;
      key_count_q <= key_count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      keyed_q     <= keyed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q   <= si_d;
    sj_q   <= sj_d;
    byte_q <= byte_d;
    res_q  <= res_d;
  end

endmodule

@@ design/rc4_variant_stream_cipher_core.sv @@
// Top level of the RC4-variant stream cipher core: RAMs, sequencer and
// output register. Depends on rc4v_pkg, rc4v_ram and rc4v_seq.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one byte per
//   transfer. mode=0 loads a key byte; the byte with key_last=1 completes the
//   key and starts the schedule. mode=1 carries a data byte, which returns
//   on the output channel (out_valid_o / out_ready_i / out_data_o) XORed with
//   the next keystream byte, or unchanged with keyed=0 before any key.
//   Key bytes give no output.
//   A keyed data byte waits on the dependent reads and swap writes on the
//   single permutation table port: read S[i], read S[j], write S[i], write
//   S[j], then read the keystream byte. An unkeyed byte goes straight to
//   the output. The final key byte adds a table init over all 256 entries
//   plus 256 schedule steps, bound by the same table port.
//   The block takes one item at a time; in_ready_o is low while an item is
//   in flight. A finished result sits in the output register, and the next
//   input is taken while it waits; if the receiver stalls, the following
//   data byte holds in the core until the register frees.
//   Reset clears the indices, key count and keyed flag; table contents stay
//   undefined until the first key schedule writes them.
module rc4_variant_stream_cipher_core
  import rc4v_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  ram_req_t   perm_req;
  ram_req_t   key_req;
  logic [7:0] perm_rdata;
  logic [7:0] key_rdata;
  logic       slot_free;
  logic       res_valid;
  out_t       res;
  logic       out_valid_q, out_valid_d;
  out_t       out_q;

  rc4v_ram #(
    .WIDTH(8),
    .DEPTH(TABLE_DEPTH)
  ) u_perm_ram (
    .clk_i  (clk_i),
    .we_i   (perm_req.we),
    .waddr_i(perm_req.waddr),
    .wdata_i(perm_req.wdata),
    .raddr_i(perm_req.raddr),
    .rdata_o(perm_rdata)
  );

  rc4v_ram #(
    .WIDTH(8),
    .DEPTH(TABLE_DEPTH)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_req.we),
    .waddr_i(key_req.waddr),
    .wdata_i(key_req.wdata),
    .raddr_i(key_req.raddr),
    .rdata_o(key_rdata)
  );

  rc4v_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .perm_req_o  (perm_req),
    .perm_rdata_i(perm_rdata),
    .key_req_o   (key_req),
    .key_rdata_i (key_rdata)
  );

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && slot_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && slot_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
